FILE: src/tlc_pkg.sv
// ----------------------------------------------------------------------------
// tlc_pkg
// Shared types and character constants for the token literal classifier.
// ----------------------------------------------------------------------------
package tlc_pkg;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_POINT = 8'h2E;
    localparam logic [7:0] CH_E_LO  = 8'h65;
    localparam logic [7:0] CH_E_UP  = 8'h45;
    localparam logic [6:0] CH_ZERO  = 7'h30;
    localparam logic [6:0] CH_NINE  = 7'h39;
    localparam logic [6:0] CH_SPACE = 7'h20;
    localparam logic [6:0] CH_DEL   = 7'h7F;

    localparam int TRUE_LEN  = 4;
    localparam int FALSE_LEN = 5;

    localparam logic [7:0] WORD_TRUE  [TRUE_LEN]  = '{8'h54, 8'h52, 8'h55, 8'h45};
    localparam logic [7:0] WORD_FALSE [FALSE_LEN] = '{8'h46, 8'h41, 8'h4C, 8'h53, 8'h45};

    // Per-byte class word passed from front to back.
    typedef struct packed {
        logic                 term;
        logic                 ctrl;
        logic                 dig;
        logic                 sgn;
        logic                 dash;
        logic                 pt;
        logic                 ex;
        logic [TRUE_LEN-1:0]  kw_true;
        logic [FALSE_LEN-1:0] kw_false;
    } t_cls;

    typedef struct packed {
        logic is_boolean;
        logic is_character;
        logic is_string;
        logic is_integer;
        logic is_real;
        logic is_flag;
    } t_res;

endpackage

FILE: src/tlc_front.sv
// ----------------------------------------------------------------------------
// tlc_front
// Classifies one raw byte into a class word for the recognizers.
// ----------------------------------------------------------------------------
module tlc_front (
    input  logic [7:0]   i_char_code,
    output tlc_pkg::t_cls o_cls
);
    import tlc_pkg::*;

    logic [6:0] w_low7;

    assign w_low7 = i_char_code[6:0];

    always_comb begin
        o_cls      = '0;
        o_cls.term = (i_char_code == CH_NUL);
        o_cls.ctrl = (w_low7 < CH_SPACE) || (w_low7 == CH_DEL);
        o_cls.dig  = (w_low7 >= CH_ZERO) && (w_low7 <= CH_NINE);
        o_cls.sgn  = (i_char_code == CH_PLUS) || (i_char_code == CH_DASH);
        o_cls.dash = (i_char_code == CH_DASH);
        o_cls.pt   = (i_char_code == CH_POINT);
        o_cls.ex   = (i_char_code == CH_E_LO) || (i_char_code == CH_E_UP);
        for (int k = 0; k < TRUE_LEN; k++) begin
            o_cls.kw_true[k] = (i_char_code == WORD_TRUE[k]);
        end
        for (int k = 0; k < FALSE_LEN; k++) begin
            o_cls.kw_false[k] = (i_char_code == WORD_FALSE[k]);
        end
    end

endmodule

FILE: src/tlc_queue.sv
// ----------------------------------------------------------------------------
// tlc_queue
// Short FIFO of class words between the front and the back.
// ----------------------------------------------------------------------------
module tlc_queue #(
    parameter int DEPTH = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  tlc_pkg::t_cls i_data,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output tlc_pkg::t_cls o_data
);
    import tlc_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_cls             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             w_wr;
    logic             w_rd;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_wr) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (w_rd) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (w_wr && !w_rd) begin
                r_count <= r_count + CNT_W'(1);
            end else if (w_rd && !w_wr) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule

FILE: src/tlc_back.sv
// ----------------------------------------------------------------------------
// tlc_back
// Recognizer state machines; emits one result word per terminated token.
// ----------------------------------------------------------------------------
module tlc_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  tlc_pkg::t_cls i_cls,
    output logic          o_take,
    input  logic          i_pop,
    output logic          o_res_valid,
    output tlc_pkg::t_res o_res
);
    import tlc_pkg::*;

    typedef enum logic [3:0] {
        RP_START, RP_SIGN, RP_INT, RP_PT_LEAD, RP_PT_BARE,
        RP_FRAC, RP_EXP_MARK, RP_EXP_SIGN, RP_EXP_DIG, RP_DEAD
    } t_real_ph;

    typedef enum logic [1:0] {
        IP_START, IP_SIGN, IP_DIG, IP_DEAD
    } t_int_ph;

    t_real_ph   r_real, n_real;
    t_int_ph    r_int, n_int;
    logic [2:0] r_kw_pos;
    logic [1:0] r_kw_alive, n_kw_alive;
    logic [1:0] r_len;
    logic       r_ctrl;
    logic       r_dash;
    logic       r_res_valid;
    t_res       r_res, n_res;

    assign o_take      = i_valid && (!i_cls.term || !r_res_valid || i_pop);
    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

    always_comb begin
        n_real = RP_DEAD;
        case (r_real)
            RP_START: begin
                if (i_cls.sgn)      n_real = RP_SIGN;
                else if (i_cls.dig) n_real = RP_INT;
                else if (i_cls.pt)  n_real = RP_PT_BARE;
            end
            RP_SIGN: begin
                if (i_cls.dig)      n_real = RP_INT;
                else if (i_cls.pt)  n_real = RP_PT_BARE;
            end
            RP_INT: begin
                if (i_cls.dig)      n_real = RP_INT;
                else if (i_cls.pt)  n_real = RP_PT_LEAD;
                else if (i_cls.ex)  n_real = RP_EXP_MARK;
            end
            RP_PT_LEAD, RP_FRAC: begin
                if (i_cls.dig)      n_real = RP_FRAC;
                else if (i_cls.ex)  n_real = RP_EXP_MARK;
            end
            RP_PT_BARE: begin
                if (i_cls.dig)      n_real = RP_FRAC;
            end
            RP_EXP_MARK: begin
                if (i_cls.sgn)      n_real = RP_EXP_SIGN;
                else if (i_cls.dig) n_real = RP_EXP_DIG;
            end
            RP_EXP_SIGN, RP_EXP_DIG: begin
                if (i_cls.dig)      n_real = RP_EXP_DIG;
            end
            default: n_real = RP_DEAD;
        endcase
    end

    always_comb begin
        n_int = IP_DEAD;
        case (r_int)
            IP_START: begin
                if (i_cls.sgn)      n_int = IP_SIGN;
                else if (i_cls.dig) n_int = IP_DIG;
            end
            IP_SIGN, IP_DIG: begin
                if (i_cls.dig)      n_int = IP_DIG;
            end
            default: n_int = IP_DEAD;
        endcase
    end

    always_comb begin
        n_kw_alive = r_kw_alive;
        if (!((r_kw_pos < 3'(TRUE_LEN)) && i_cls.kw_true[r_kw_pos[1:0]])) begin
            n_kw_alive[0] = 1'b0;
        end
        if (!((r_kw_pos < 3'(FALSE_LEN)) && i_cls.kw_false[r_kw_pos])) begin
            n_kw_alive[1] = 1'b0;
        end
    end

    always_comb begin
        n_res.is_boolean   = (r_kw_alive[0] && (r_kw_pos == 3'(TRUE_LEN))) ||
                             (r_kw_alive[1] && (r_kw_pos == 3'(FALSE_LEN)));
        n_res.is_string    = !r_ctrl;
        n_res.is_character = (r_len == 2'd1) && !r_ctrl;
        n_res.is_integer   = (r_int == IP_DIG);
        n_res.is_real      = (r_real == RP_INT) || (r_real == RP_PT_LEAD) ||
                             (r_real == RP_FRAC) || (r_real == RP_EXP_DIG);
        n_res.is_flag      = !r_ctrl && r_dash && (r_len == 2'd2);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_real      <= RP_START;
            r_int       <= IP_START;
            r_kw_pos    <= '0;
            r_kw_alive  <= 2'b11;
            r_len       <= '0;
            r_ctrl      <= 1'b0;
            r_dash      <= 1'b0;
            r_res_valid <= 1'b0;
        end else if (o_take && i_cls.term) begin
            r_res       <= n_res;
            r_res_valid <= 1'b1;
            r_real      <= RP_START;
            r_int       <= IP_START;
            r_kw_pos    <= '0;
            r_kw_alive  <= 2'b11;
            r_len       <= '0;
            r_ctrl      <= 1'b0;
            r_dash      <= 1'b0;
        end else begin
            if (i_pop) begin
                r_res_valid <= 1'b0;
            end
            if (o_take) begin
                r_real     <= n_real;
                r_int      <= n_int;
                r_kw_alive <= n_kw_alive;
                if (r_kw_pos != 3'd7) begin
                    r_kw_pos <= r_kw_pos + 3'd1;
                end
                if ((r_len == 2'd0) && i_cls.dash) begin
                    r_dash <= 1'b1;
                end
                if (i_cls.ctrl) begin
                    r_ctrl <= 1'b1;
                end
                if (r_len != 2'd2) begin
                    r_len <= r_len + 2'd1;
                end
            end
        end
    end

endmodule

FILE: src/token_literal_classifier.sv
// ----------------------------------------------------------------------------
// token_literal_classifier
// Classifies a zero-terminated token, one byte per word, into six flags.
//
//   channel  | handshake          | payload
//   ---------+--------------------+------------------------------------------
//   input    | push / full        | i_char_code
//   result   | empty / pop        | o_is_boolean .. o_is_flag
//
// One byte word is taken per cycle while full is low; the result reaches the
// outputs via the class queue and result register after the terminating zero
// byte is accepted. The back end consumes one queued word per cycle; it holds
// the terminator only while an untaken result occupies the result register.
// Reset is synchronous and clears queue, recognizers and result valid.
// ----------------------------------------------------------------------------
module token_literal_classifier #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] i_char_code,
    output logic       empty,
    input  logic       pop,
    output logic       o_is_boolean,
    output logic       o_is_character,
    output logic       o_is_string,
    output logic       o_is_integer,
    output logic       o_is_real,
    output logic       o_is_flag
);
    import tlc_pkg::*;

    t_cls w_cls_in;
    t_cls w_cls_q;
    logic w_q_valid;
    logic w_take;
    logic w_res_valid;
    t_res w_res;

    tlc_front u_front (
        .i_char_code (i_char_code),
        .o_cls       (w_cls_in)
    );

    tlc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (w_cls_in),
        .o_full  (full),
        .i_pop   (w_take),
        .o_valid (w_q_valid),
        .o_data  (w_cls_q)
    );

    tlc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (w_q_valid),
        .i_cls       (w_cls_q),
        .o_take      (w_take),
        .i_pop       (pop),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    assign empty          = !w_res_valid;
    assign o_is_boolean   = w_res.is_boolean;
    assign o_is_character = w_res.is_character;
    assign o_is_string    = w_res.is_string;
    assign o_is_integer   = w_res.is_integer;
    assign o_is_real      = w_res.is_real;
    assign o_is_flag      = w_res.is_flag;

endmodule

FILE: src/tlc_checker.sv
// ----------------------------------------------------------------------------
// tlc_checker
// Port-level checks on the token literal classifier.
// ----------------------------------------------------------------------------
module tlc_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic full,
    input logic empty,
    input logic pop,
    input logic o_is_boolean,
    input logic o_is_character,
    input logic o_is_string,
    input logic o_is_integer,
    input logic o_is_real,
    input logic o_is_flag
);

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> (empty && !full))
        else $error("queue not cleared by reset");

    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable({o_is_boolean, o_is_character,
            o_is_string, o_is_integer, o_is_real, o_is_flag})))
        else $error("waiting result changed or dropped");

    a_subclass_string: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> ((!o_is_character && !o_is_flag && !o_is_boolean) || o_is_string))
        else $error("character, flag or boolean without string");

    a_integer_is_real: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (!o_is_integer || o_is_real))
        else $error("integer not recognized as real");

    a_boolean_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (!o_is_boolean || (!o_is_integer && !o_is_real && !o_is_character)))
        else $error("boolean overlaps numeric or character class");

endmodule

bind token_literal_classifier tlc_checker u_tlc_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .full           (full),
    .empty          (empty),
    .pop            (pop),
    .o_is_boolean   (o_is_boolean),
    .o_is_character (o_is_character),
    .o_is_string    (o_is_string),
    .o_is_integer   (o_is_integer),
    .o_is_real      (o_is_real),
    .o_is_flag      (o_is_flag)
);
